[src/fbfl_pkg.sv]
// Shared types, codes and constants of the fixed block free list allocator.
package fbfl_pkg;

  localparam int unsigned HW = 7;
  localparam int unsigned POOL_DEPTH_DEF = 64;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [HW-1:0] BLOCK_COUNT_RST = 7'd64;
  localparam logic [HW-1:0] COUNT_MAX = 7'h7F;
  localparam logic [HW-1:0] NULL_HANDLE = 7'd0;

  localparam logic [PADDR_W-1:0] REG_BLOCK_COUNT = 3'd0;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE = 2'd1;
  localparam logic [1:0] MODE_INIT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SWEEP,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic [HW-1:0] handle;
    logic          empty;
    logic [HW-1:0] used;
    logic [HW-1:0] peak;
  } res_t;

endpackage

[src/fixed_block_free_list_allocator_unit.sv]
// Top level of the fixed block free list allocator: control, counters and link RAM.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------------
//  in      | input     | in_valid_i / in_stall_o  | mode_i, handle_in_i
//  out     | output    | out_valid_o / out_stall_i| handle_out_o, pool_empty_o,
//          |           |                        | used_blocks_o, peak_blocks_o
//  cfg     | input     | APB psel/penable/pready  | block_count at byte address 0
//
// Free, failed allocate and unused mode finish in the cycle they are taken; a successful
// allocate first waits in ST_READ for the registered read port of the link RAM.
// Initialize writes min(block_count, POOL_DEPTH) links in ST_SWEEP, one link per cycle.
// After reset the block links min(64, POOL_DEPTH) blocks, one per cycle, with in_stall_o
// high; no beat comes out of that pass.
// A finished result waits in a holding register while the output is stalled; the next
// beat is taken once that register has moved on.
module fixed_block_free_list_allocator_unit
  import fbfl_pkg::*;
#(
  parameter int unsigned POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [HW-1:0]      handle_in_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [HW-1:0]      handle_out_o,
  output logic               pool_empty_o,
  output logic [HW-1:0]      used_blocks_o,
  output logic [HW-1:0]      peak_blocks_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam logic [HW-1:0] DEPTH_CAP =
    (POOL_DEPTH > 127) ? COUNT_MAX : HW'(POOL_DEPTH);
  localparam logic [HW-1:0] RST_COUNT =
    (BLOCK_COUNT_RST > DEPTH_CAP) ? DEPTH_CAP : BLOCK_COUNT_RST;

  state_e        state_q, state_d;
  logic [HW-1:0] block_count_q;
  logic [HW-1:0] head_q, head_d;
  logic [HW-1:0] used_q, used_d;
  logic [HW-1:0] peak_q, peak_d;
  logic [HW-1:0] sweep_q, sweep_d;
  logic [HW-1:0] init_n_q, init_n_d;
  logic          report_q, report_d;
  logic          out_valid_q, out_valid_d;
  res_t          out_q, pend_q, res;

  logic          accept, out_free, done, head_ok, free_ok, sweep_last;
  logic [HW-1:0] init_n;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [HW-1:0] mem_wdata, mem_rdata;

  // ---------------------------------------------------------------- config port
  assign pready = 1'b1;
  assign prdata = (paddr == REG_BLOCK_COUNT) ? PDATA_W'(block_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= BLOCK_COUNT_RST;
    end else if (psel && penable && pwrite && pready && paddr == REG_BLOCK_COUNT) begin
      block_count_q <= pwdata[HW-1:0];
    end
  end

  // ---------------------------------------------------------------- control
  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign head_ok    = (head_q != NULL_HANDLE) && (32'(head_q) <= POOL_DEPTH);
  assign free_ok    = (handle_in_i != NULL_HANDLE) && (32'(handle_in_i) <= POOL_DEPTH);
  assign init_n     = (block_count_q > DEPTH_CAP) ? DEPTH_CAP : block_count_q;
  assign sweep_last = (sweep_q == init_n_q);

  // datapath and RAM control
  always_comb begin
    head_d    = head_q;
    used_d    = used_q;
    peak_d    = peak_q;
    sweep_d   = sweep_q;
    init_n_d  = init_n_q;
    report_d  = report_q;
    done      = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = AW'(handle_in_i - HW'(1));
    mem_wdata = head_q;
    mem_raddr = AW'(head_q - HW'(1));
    res       = '{handle: NULL_HANDLE, empty: 1'b0, used: used_q, peak: peak_q};

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (mode_i)
            MODE_ALLOC: begin
              if (head_ok) begin
                mem_re = 1'b1;
              end else begin
                res.empty = 1'b1;
                done      = 1'b1;
              end
            end
            MODE_FREE: begin
              if (free_ok) begin
                mem_we = 1'b1;
                head_d = handle_in_i;
                used_d = (used_q == '0) ? '0 : used_q - HW'(1);
              end
              done = 1'b1;
            end
            MODE_INIT: begin
              head_d   = (init_n == '0) ? NULL_HANDLE : HW'(1);
              used_d   = '0;
              peak_d   = '0;
              sweep_d  = HW'(1);
              init_n_d = init_n;
              report_d = 1'b1;
              done     = (init_n == '0);
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        // link of the popped block arrives now
        head_d     = mem_rdata;
        used_d     = (used_q == COUNT_MAX) ? COUNT_MAX : used_q + HW'(1);
        peak_d     = (used_d > peak_q) ? used_d : peak_q;
        res.handle = head_q;
        done       = 1'b1;
      end
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(sweep_q - HW'(1));
        mem_wdata = sweep_last ? NULL_HANDLE : sweep_q + HW'(1);
        sweep_d   = sweep_q + HW'(1);
        done      = sweep_last && report_q;
      end
      ST_HOLD: begin
        done = 1'b0;
      end
      default: begin
        done = 1'b0;
      end
    endcase

    res.used = used_d;
    res.peak = peak_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && mode_i == MODE_ALLOC && head_ok) begin
          state_d = ST_READ;
        end else if (accept && mode_i == MODE_INIT && init_n != '0) begin
          state_d = ST_SWEEP;
        end else if (done && !out_free) begin
          state_d = ST_HOLD;
        end
      end
      ST_READ: begin
        state_d = out_free ? ST_IDLE : ST_HOLD;
      end
      ST_SWEEP: begin
        if (sweep_last) begin
          state_d = (report_q && !out_free) ? ST_HOLD : ST_IDLE;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = ((done || state_q == ST_HOLD) && out_free) ||
                       (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      head_q      <= HW'(1);
      used_q      <= '0;
      peak_q      <= '0;
      sweep_q     <= HW'(1);
      init_n_q    <= RST_COUNT;
      report_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      used_q      <= used_d;
      peak_q      <= peak_d;
      sweep_q     <= sweep_d;
      init_n_q    <= init_n_d;
      report_q    <= report_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload: load the output register, or park the result while it is stalled
  always_ff @(posedge clk_i) begin
    if (done && !out_free) begin
      pend_q <= res;
    end
    if (out_free) begin
      if (state_q == ST_HOLD) begin
        out_q <= pend_q;
      end else if (done) begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign handle_out_o  = out_q.handle;
  assign pool_empty_o  = out_q.empty;
  assign used_blocks_o = out_q.used;
  assign peak_blocks_o = out_q.peak;

  // ---------------------------------------------------------------- link RAM
  fbfl_ram #(
    .WIDTH(HW),
    .DEPTH(POOL_DEPTH)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // ---------------------------------------------------------------- assertions
  a_peak_covers_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= peak_q)
    else $error("used count above peak count");

  a_free_sets_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && mode_i == MODE_FREE && free_ok |=> head_q == $past(handle_in_i))
    else $error("freed handle did not become list head");

  a_read_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |=> state_q != ST_READ)
    else $error("link read wait lasted more than one cycle");

  a_hold_needs_full_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_HOLD |-> out_valid_q)
    else $error("parked result while output register empty");

endmodule

[src/fbfl_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
module fbfl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[tb/fixed_block_free_list_allocator_unit_tb.sv]
// Self-checking testbench for the fixed block free list allocator unit.
`timescale 1ns / 100ps

module fixed_block_free_list_allocator_unit_tb
  import fbfl_pkg::*;
();

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 80;
  localparam int unsigned HOLD_CYCLES = 200;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         mode_i = MODE_ALLOC;
  logic [HW-1:0]      handle_in_i = NULL_HANDLE;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [HW-1:0]      handle_out_o;
  logic               pool_empty_o;
  logic [HW-1:0]      used_blocks_o;
  logic [HW-1:0]      peak_blocks_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // pool model state
  logic [HW-1:0] link_store [0:POOL_DEPTH_DEF];
  logic [HW-1:0] free_head;
  logic [HW-1:0] used_count;
  logic [HW-1:0] peak_count;
  logic [HW-1:0] cfg_block_count;

  res_t          expected_results [$];
  logic [HW-1:0] held_handles [$];
  res_t          want_beat;
  int unsigned   mismatch_count = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   send_idle_pct = 30;
  int unsigned   stall_pct = 30;
  int unsigned   hold_request = 0;
  int unsigned   hold_left = 0;

  fixed_block_free_list_allocator_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .handle_in_i   (handle_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .handle_out_o  (handle_out_o),
    .pool_empty_o  (pool_empty_o),
    .used_blocks_o (used_blocks_o),
    .peak_blocks_o (peak_blocks_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void relink_pool();
    int unsigned count;
    count = (cfg_block_count > POOL_DEPTH_DEF) ? POOL_DEPTH_DEF : cfg_block_count;
    for (int unsigned k = 1; k <= count; k++) begin
      link_store[k] = (k == count) ? NULL_HANDLE : HW'(k + 1);
    end
    free_head = (count == 0) ? NULL_HANDLE : HW'(1);
    used_count = '0;
    peak_count = '0;
  endfunction

  function automatic res_t pool_step(input logic [1:0] mode, input logic [HW-1:0] handle);
    res_t beat;
    beat = '0;
    case (mode)
      MODE_ALLOC: begin
        if (free_head != NULL_HANDLE && free_head <= POOL_DEPTH_DEF) begin
          beat.handle = free_head;
          free_head = link_store[free_head];
          if (used_count < COUNT_MAX) used_count = used_count + 1'b1;
          if (used_count > peak_count) peak_count = used_count;
        end else begin
          beat.empty = 1'b1;
        end
      end
      MODE_FREE: begin
        // null and out-of-range handles leave the pool alone
        if (handle != NULL_HANDLE && handle <= POOL_DEPTH_DEF) begin
          link_store[handle] = free_head;
          free_head = handle;
          if (used_count != 0) used_count = used_count - 1'b1;
        end
      end
      MODE_INIT: relink_pool();
      default: ;
    endcase
    beat.used = used_count;
    beat.peak = peak_count;
    return beat;
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  // Offer one beat after a random gap and predict its result once it is taken.
  task automatic send_item(input logic [1:0] mode, input logic [HW-1:0] handle);
    res_t predicted;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    handle_in_i <= handle;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = pool_step(mode, handle);
    expected_results.push_back(predicted);
    if (mode == MODE_INIT) held_handles.delete();
    if (mode == MODE_ALLOC && !predicted.empty) held_handles.push_back(predicted.handle);
  endtask

  task automatic send_free_of_held();
    int unsigned pick;
    logic [HW-1:0] handle;
    if (held_handles.size() == 0) begin
      send_item(MODE_FREE, HW'($urandom_range(1, POOL_DEPTH_DEF)));
    end else begin
      pick = $urandom_range(held_handles.size() - 1);
      handle = held_handles[pick];
      held_handles.delete(pick);
      send_item(MODE_FREE, handle);
    end
  endtask

  // Drop valid and wait until every result is back and the block takes input again.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic set_block_count(input logic [HW-1:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_BLOCK_COUNT;
    pwdata <= ($urandom() << HW) | PDATA_W'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    cfg_block_count = value;
    // read back
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[HW-1:0] !== cfg_block_count) begin
      report_mismatch("block_count readback", cfg_block_count, prdata[HW-1:0]);
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_directed_cases();
    send_item(MODE_ALLOC, 7'd127);
    send_item(MODE_ALLOC, 7'd0);
    send_item(MODE_FREE, NULL_HANDLE);
    send_item(MODE_FREE, 7'd127);
    send_item(MODE_FREE, 7'd65);
    send_item(MODE_UNUSED, 7'h55);
    send_item(MODE_FREE, 7'd2);
    // second free of the same block loops the list onto itself
    send_item(MODE_FREE, 7'd2);
    send_item(MODE_ALLOC, 7'h2A);
    send_item(MODE_ALLOC, 7'd0);
    send_item(MODE_INIT, 7'h2A);
    send_item(MODE_FREE, 7'd5);
    send_item(MODE_ALLOC, 7'd0);
    drain_results();
    set_block_count(7'd1);
    send_item(MODE_INIT, 7'd0);
    send_item(MODE_ALLOC, 7'd0);
    send_item(MODE_ALLOC, 7'd0);
    send_item(MODE_FREE, 7'd64);
    send_item(MODE_ALLOC, 7'd0);
    send_item(MODE_ALLOC, 7'd0);
    drain_results();
    set_block_count(7'd0);
    send_item(MODE_INIT, 7'd0);
    send_item(MODE_ALLOC, 7'd0);
    send_item(MODE_FREE, 7'd1);
    send_item(MODE_ALLOC, 7'd0);
    send_item(MODE_ALLOC, 7'd0);
  endtask

  task automatic test_pool_sizes();
    logic [HW-1:0] sizes [3];
    int unsigned linked;
    sizes = '{7'd127, 7'd3, HW'($urandom_range(1, POOL_DEPTH_DEF - 1))};
    foreach (sizes[i]) begin
      drain_results();
      set_block_count(sizes[i]);
      send_item(MODE_INIT, HW'($urandom_range(127)));
      linked = (sizes[i] > POOL_DEPTH_DEF) ? POOL_DEPTH_DEF : sizes[i];
      // one more than the pool holds, so the last one comes back empty
      repeat (linked + 1) send_item(MODE_ALLOC, HW'($urandom_range(127)));
      while (held_handles.size() != 0) send_free_of_held();
    end
  endtask

  task automatic test_double_free_cycle();
    logic [HW-1:0] handle;
    drain_results();
    set_block_count(7'd4);
    send_item(MODE_INIT, 7'd0);
    send_item(MODE_ALLOC, 7'd0);
    handle = held_handles.pop_back();
    send_item(MODE_FREE, handle);
    send_item(MODE_FREE, handle);
    // the list is now a loop: run the used count into saturation
    repeat (130) send_item(MODE_ALLOC, HW'($urandom_range(127)));
  endtask

  task automatic test_random_traffic();
    int unsigned pick;
    for (int n = 0; n < 500; n++) begin
      if (n % 125 == 0) begin
        drain_results();
        case ($urandom_range(4))
          0: set_block_count(7'd0);
          1: set_block_count(7'd1);
          2: set_block_count(7'd64);
          3: set_block_count(7'd127);
          default: set_block_count(HW'($urandom_range(1, POOL_DEPTH_DEF)));
        endcase
        send_item(MODE_INIT, HW'($urandom_range(127)));
      end
      // a stretch with no gaps on either side
      if (n == 250) begin
        send_idle_pct = 0;
        stall_pct = 0;
      end else if (n == 350) begin
        send_idle_pct = 30;
        stall_pct = 30;
      end
      pick = $urandom_range(99);
      if (pick < 45) send_item(MODE_ALLOC, HW'($urandom_range(127)));
      else if (pick < 80) send_free_of_held();
      else if (pick < 92) send_item(MODE_FREE, HW'($urandom_range(127)));
      else if (pick < 96) send_item(MODE_UNUSED, HW'($urandom_range(127)));
      else send_item(MODE_INIT, HW'($urandom_range(127)));
    end
  endtask

  task automatic test_output_hold();
    drain_results();
    send_idle_pct = 0;
    hold_request = HOLD_CYCLES;
    repeat (40) begin
      if ($urandom_range(1)) send_item(MODE_ALLOC, HW'($urandom_range(127)));
      else send_free_of_held();
    end
    send_idle_pct = 30;
  endtask

  // receiver stall, with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("beat with nothing outstanding, handle", -1, handle_out_o);
      end else begin
        want_beat = expected_results.pop_front();
        if (handle_out_o !== want_beat.handle)
          report_mismatch("handle_out", want_beat.handle, handle_out_o);
        if (pool_empty_o !== want_beat.empty)
          report_mismatch("pool_empty", want_beat.empty, pool_empty_o);
        if (used_blocks_o !== want_beat.used)
          report_mismatch("used_blocks", want_beat.used, used_blocks_o);
        if (peak_blocks_o !== want_beat.peak)
          report_mismatch("peak_blocks", want_beat.peak, peak_blocks_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int k = 0; k <= POOL_DEPTH_DEF; k++) link_store[k] = NULL_HANDLE;
    cfg_block_count = BLOCK_COUNT_RST;
    relink_pool();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_pool_sizes();
    test_double_free_cycle();
    test_random_traffic();
    test_output_hold();
    drain_results();
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    mismatch_count += expected_results.size();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
